[hw/rtl/lru_keyed_handle_cache_unit_macros.svh]
// ----------------------------------------------------------------------------
// lru keyed handle cache assertion macros
// shared assertion wrappers, clocked on clk, reset rst
// ----------------------------------------------------------------------------
`ifndef LRU_KEYED_HANDLE_CACHE_UNIT_MACROS_SVH
`define LRU_KEYED_HANDLE_CACHE_UNIT_MACROS_SVH

// property checked outside of reset
`define LKH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every edge, reset included
`define LKH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/lkh_pkg.sv]
// ----------------------------------------------------------------------------
// lkh_pkg
// shared types and constants of the lru keyed handle cache
// ----------------------------------------------------------------------------
package lkh_pkg;

  // table geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int DATA_W   = KEY_W + VAL_W;

  // configuration register
  localparam int MAX_W    = 5;
  localparam int ADDR_W   = 3;
  localparam int PDATA_W  = 32;
  localparam logic [0:0]       REG_MAX_ENTRIES = 1'b0;
  localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = 5'd16;

  // command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_STORE  = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SCAN,
    ST_REMOVE,
    ST_INSERT,
    ST_TOUCH
  } lkh_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the transaction
    logic evict;      // drop entries ranked at or beyond the limit minus one
    logic scan_init;  // clear search flags
    logic scan;       // step the key search
    logic remove;     // drop the old copy of the key
    logic insert;     // write the new entry, store result
    logic touch;      // lookup result
    logic promote;    // make the hit entry most recent
  } lkh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic hit;
  } lkh_stat_t;

endpackage

[hw/rtl/lkh_ram.sv]
// ----------------------------------------------------------------------------
// lkh_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lkh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/lkh_ctrl.sv]
// ----------------------------------------------------------------------------
// lkh_ctrl
// sequencer for one lookup or store transaction
// ----------------------------------------------------------------------------
`include "lru_keyed_handle_cache_unit_macros.svh"

module lkh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              command,
  output logic              busy,
  output lkh_pkg::lkh_cmd_t cmd,
  input  lkh_pkg::lkh_stat_t stat
);

  lkh_pkg::lkh_state_t state, state_next;
  logic                is_store, is_store_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lkh_pkg::ST_IDLE;
      is_store <= 1'b0;
    end else begin
      state    <= state_next;
      is_store <= is_store_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    is_store_next = is_store;
    cmd           = '0;
    unique case (state)
      lkh_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load      = 1'b1;
          is_store_next = (command == lkh_pkg::CMD_STORE);
          if (command == lkh_pkg::CMD_STORE) begin
            state_next = lkh_pkg::ST_EVICT;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = lkh_pkg::ST_SCAN;
          end
        end
      end
      lkh_pkg::ST_EVICT: begin
        cmd.evict     = 1'b1;
        cmd.scan_init = 1'b1;
        state_next    = lkh_pkg::ST_SCAN;
      end
      lkh_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = is_store ? lkh_pkg::ST_REMOVE : lkh_pkg::ST_TOUCH;
        end
      end
      lkh_pkg::ST_REMOVE: begin
        cmd.remove = stat.hit;
        state_next = lkh_pkg::ST_INSERT;
      end
      lkh_pkg::ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = lkh_pkg::ST_IDLE;
      end
      lkh_pkg::ST_TOUCH: begin
        cmd.touch   = 1'b1;
        cmd.promote = stat.hit;
        state_next  = lkh_pkg::ST_IDLE;
      end
      default: begin
        state_next = lkh_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != lkh_pkg::ST_IDLE);

  // an accepted transaction always keeps the block busy for the next cycle
  `LKH_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy, "accepted transaction not started")

endmodule

[hw/rtl/lkh_datapath.sv]
// ----------------------------------------------------------------------------
// lkh_datapath
// entry table, recency ranks, key search and result registers
// ----------------------------------------------------------------------------
`include "lru_keyed_handle_cache_unit_macros.svh"

module lkh_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  lkh_pkg::lkh_cmd_t          cmd,
  output lkh_pkg::lkh_stat_t         stat,
  input  logic [lkh_pkg::MAX_W-1:0]  max_entries,
  input  logic [lkh_pkg::KEY_W-1:0]  key,
  input  logic [lkh_pkg::VAL_W-1:0]  value_in,
  output logic                       done,
  output logic                       found,
  output logic [lkh_pkg::VAL_W-1:0]  value_out
);

  // per entry state
  logic [lkh_pkg::CAPACITY-1:0] valid;
  logic [lkh_pkg::IDX_W-1:0]    rank [lkh_pkg::CAPACITY];
  logic [lkh_pkg::CNT_W-1:0]    count;

  // transaction registers
  logic [lkh_pkg::KEY_W-1:0]    key_q;
  logic [lkh_pkg::VAL_W-1:0]    value_q;

  // search state
  logic [lkh_pkg::CNT_W-1:0]    scan_addr;
  logic                         rd_vld;
  logic [lkh_pkg::IDX_W-1:0]    rd_idx;
  logic                         hit;
  logic [lkh_pkg::IDX_W-1:0]    hit_idx;
  logic [lkh_pkg::VAL_W-1:0]    hit_value;
  logic                         free_found;
  logic [lkh_pkg::IDX_W-1:0]    free_idx;

  // memory side
  logic [lkh_pkg::DATA_W-1:0]   rd_data;
  logic [lkh_pkg::KEY_W-1:0]    rd_key;
  logic [lkh_pkg::VAL_W-1:0]    rd_val;
  logic                         rd_en;

  // derived control
  logic [lkh_pkg::IDX_W-1:0]    thr;
  logic [lkh_pkg::IDX_W-1:0]    hit_rank;
  logic [lkh_pkg::IDX_W-1:0]    ins_idx;
  logic                         match;
  logic                         free_hit;
  logic [lkh_pkg::CAPACITY-1:0] evict_lane;
  logic [lkh_pkg::CAPACITY-1:0] dec_lane;
  logic [lkh_pkg::CAPACITY-1:0] inc_lane;

  // key and handle storage
  lkh_ram #(
    .WIDTH (lkh_pkg::DATA_W),
    .DEPTH (lkh_pkg::CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (ins_idx),
    .wdata ({key_q, value_q}),
    .re    (rd_en),
    .raddr (scan_addr[lkh_pkg::IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign rd_key = rd_data[lkh_pkg::DATA_W-1:lkh_pkg::VAL_W];
  assign rd_val = rd_data[lkh_pkg::VAL_W-1:0];
  assign rd_en  = cmd.scan && (scan_addr < lkh_pkg::CNT_W'(lkh_pkg::CAPACITY));

  // lowest rank dropped by eviction: limit clamped to 1..CAPACITY, minus one
  always_comb begin
    if (max_entries == '0) begin
      thr = '0;
    end else if (max_entries > lkh_pkg::MAX_W'(lkh_pkg::CAPACITY)) begin
      thr = lkh_pkg::IDX_W'(lkh_pkg::CAPACITY - 1);
    end else begin
      thr = lkh_pkg::IDX_W'(max_entries - 1'b1);
    end
  end

  // search compare on the entry read last cycle
  assign match    = rd_vld && !hit && valid[rd_idx] && (rd_key == key_q);
  assign free_hit = rd_vld && !free_found && !valid[rd_idx];

  assign hit_rank = rank[hit_idx];

  // new entry goes to the lowest free slot, counting the old copy as freed
  always_comb begin
    if (hit && (!free_found || (hit_idx < free_idx))) begin
      ins_idx = hit_idx;
    end else begin
      ins_idx = free_idx;
    end
  end

  // per lane rank conditions
  always_comb begin
    for (int i = 0; i < lkh_pkg::CAPACITY; i++) begin
      evict_lane[i] = valid[i] && (rank[i] >= thr);
      dec_lane[i]   = valid[i] && (rank[i] > hit_rank);
      inc_lane[i]   = valid[i] && (rank[i] < hit_rank);
    end
  end

  // control state: valid bits, count, search flags, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      count      <= '0;
      scan_addr  <= '0;
      rd_vld     <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd.insert | cmd.touch;
      if (cmd.evict) begin
        valid <= valid & ~evict_lane;
        if (count > lkh_pkg::CNT_W'(thr)) begin
          count <= lkh_pkg::CNT_W'(thr);
        end
      end
      if (cmd.scan_init) begin
        scan_addr  <= '0;
        rd_vld     <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.scan) begin
        rd_vld <= rd_en;
        if (rd_en) begin
          scan_addr <= scan_addr + 1'b1;
        end
        if (match) begin
          hit <= 1'b1;
        end
        if (free_hit) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.remove) begin
        valid[hit_idx] <= 1'b0;
        count          <= count - 1'b1;
      end
      if (cmd.insert) begin
        valid[ins_idx] <= 1'b1;
        count          <= count + 1'b1;
      end
    end
  end

  // payload: transaction, search capture, ranks, result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q   <= key;
      value_q <= value_in;
    end
    rd_idx <= scan_addr[lkh_pkg::IDX_W-1:0];
    if (cmd.scan && match) begin
      hit_idx   <= rd_idx;
      hit_value <= rd_val;
    end
    if (cmd.scan && free_hit) begin
      free_idx <= rd_idx;
    end
    // close the gap left by the old copy
    if (cmd.remove) begin
      for (int i = 0; i < lkh_pkg::CAPACITY; i++) begin
        if (dec_lane[i]) begin
          rank[i] <= rank[i] - 1'b1;
        end
      end
    end
    // every live entry ages by one, new one is most recent
    if (cmd.insert) begin
      for (int i = 0; i < lkh_pkg::CAPACITY; i++) begin
        if (valid[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
      rank[ins_idx] <= '0;
      found         <= 1'b1;
      value_out     <= value_q;
    end
    // lookup hit moves to the front
    if (cmd.promote) begin
      for (int i = 0; i < lkh_pkg::CAPACITY; i++) begin
        if (inc_lane[i]) begin
          rank[i] <= rank[i] + 1'b1;
        end
      end
      rank[hit_idx] <= '0;
    end
    if (cmd.touch) begin
      found     <= hit;
      value_out <= hit ? hit_value : '0;
    end
  end

  assign stat.scan_done = rd_vld && (rd_idx == lkh_pkg::IDX_W'(lkh_pkg::CAPACITY - 1));
  assign stat.hit       = hit;

  // entry count tracks the valid bits
  `LKH_ASSERT_ALWAYS(a_count_matches_valid, rst || ($countones(valid) == count), "entry count out of step with valid bits")
  // eviction leaves room below the limit
  `LKH_ASSERT(a_evict_below_limit, cmd.evict |=> (count <= lkh_pkg::CNT_W'($past(thr))), "eviction left too many entries")
  // a store always reports its handle
  `LKH_ASSERT(a_store_reports, cmd.insert |=> (done && found), "store result missing")

endmodule

[hw/rtl/lru_keyed_handle_cache_unit.sv]
// ----------------------------------------------------------------------------
// lru_keyed_handle_cache_unit
// fully associative 16 entry key to handle cache with exact lru replacement
// ----------------------------------------------------------------------------
// usage:
//   a transaction is taken when start is high and busy is low; command selects
//   lookup (key) or store (key, value_in). exactly one result follows, shown
//   for one cycle with done high: found and value_out (the handle, or zero on
//   a lookup miss; a store returns its own handle with found set).
//   a lookup runs through scan and touch, a store through evict, scan, remove
//   and insert. busy stays high until the last sequencing step, so one
//   transaction is in work at a time; the key search reads one entry of the
//   key ram per cycle, and the ram read is registered.
//   the next transaction can be taken at the edge that ends the done cycle.
//   the max_entries register (byte address 0, apb, reset 16) sets the entry
//   count at which a store evicts least recent entries; 0 acts as 1 and values
//   above 16 act as 16. write it only while the block is idle.
//   reset empties the table (valid bits cleared, no sweep) and restores
//   max_entries. results cannot be held off: the receiver must take done.
// ----------------------------------------------------------------------------
module lru_keyed_handle_cache_unit (
  input  logic                         clk,
  input  logic                         rst,
  // transaction channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [lkh_pkg::KEY_W-1:0]    key,
  input  logic [lkh_pkg::VAL_W-1:0]    value_in,
  // result channel
  output logic                         done,
  output logic                         found,
  output logic [lkh_pkg::VAL_W-1:0]    value_out,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lkh_pkg::ADDR_W-1:0]   paddr,
  input  logic [lkh_pkg::PDATA_W-1:0]  pwdata,
  output logic [lkh_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [lkh_pkg::MAX_W-1:0] max_entries;
  logic                      reg_sel;
  lkh_pkg::lkh_cmd_t         cmd;
  lkh_pkg::lkh_stat_t        stat;

  // register decode on word address
  assign reg_sel = (paddr[lkh_pkg::ADDR_W-1] == lkh_pkg::REG_MAX_ENTRIES);
  assign pready  = 1'b1;

  // max_entries register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= lkh_pkg::MAX_ENTRIES_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      max_entries <= pwdata[lkh_pkg::MAX_W-1:0];
    end
  end

  // register read back
  assign prdata = reg_sel ? lkh_pkg::PDATA_W'(max_entries) : '0;

  // sequencer
  lkh_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .busy    (busy),
    .cmd     (cmd),
    .stat    (stat)
  );

  // table and search
  lkh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .max_entries (max_entries),
    .key         (key),
    .value_in    (value_in),
    .done        (done),
    .found       (found),
    .value_out   (value_out)
  );

endmodule
